// ----- rtl/core/edac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edac_pkg
// Shared constants and controller/datapath interface types for the
// Euclidean distance accumulator.
// ----------------------------------------------------------------------------
package edac_pkg;

  localparam int MAX_DIM_DEF   = 1024;
  localparam int ELEM_BITS_DEF = 16;

  // Running sum of squares and its saturation value.
  localparam int          SUM_W   = 44;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // The square root of a SUM_W-bit value has SUM_W/2 bits; the reported
  // distance is clamped to DIST_W bits.
  localparam int ROOT_W     = SUM_W / 2;
  localparam int DIST_W     = 21;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic root_step;  // advance the square root by one result bit
    logic out_load;   // move the finished distance into the output register
  } edac_cmd_t;

  typedef struct packed {
    logic root_last;  // the square root is on its final step
  } edac_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/edac_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edac_ctrl
// Controller: gates the input stream, sequences the bit-serial square root
// at the end of each vector and owns the output valid flag.
// ----------------------------------------------------------------------------
module edac_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_valid_i,
  input  wire logic                   s_last_i,
  output logic                        s_ready_o,
  output logic                        m_valid_o,
  input  wire logic                   m_ready_i,
  output edac_pkg::edac_cmd_t         cmd_o,
  input  wire edac_pkg::edac_status_t status_i
);
  import edac_pkg::*;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DRAIN,
    ST_ROOT,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = s_valid_i && (state_q == ST_ACC);
    cmd_o.root_step = (state_q == ST_ROOT);
    cmd_o.out_load  = (state_q == ST_FIN) && out_free;
  end

  assign s_ready_o = (state_q == ST_ACC);
  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACC;
      m_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_ACC: begin
          if (s_valid_i && s_last_i) begin
            state_q <= ST_DRAIN;
          end
        end
        // The last beat reaches the accumulator and is handed to the root unit.
        ST_DRAIN: begin
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (status_i.root_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_ACC;
          end
        end
        default: begin
          state_q <= ST_ACC;
        end
      endcase

      if (cmd_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o && s_last_i) |=> !s_ready_o)
    else $error("input not stalled after last beat");

  a_load_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> m_valid_o)
    else $error("loaded result not presented");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && m_valid_o && !m_ready_i) |=> (state_q == ST_FIN))
    else $error("result overwritten before it was taken");

  a_root_then_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && status_i.root_last) |=> (state_q == ST_FIN && !s_ready_o))
    else $error("square root sequence broken");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/edac_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edac_dp
// Datapath: difference and square stage, saturating accumulator with element
// counter, bit-serial floor square root and the output register.
// ----------------------------------------------------------------------------
module edac_dp #(
  parameter int MAX_DIM   = edac_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = edac_pkg::ELEM_BITS_DEF,
  parameter int IN_DATA_W = ((2 * edac_pkg::ELEM_BITS_DEF + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire edac_pkg::edac_cmd_t               cmd_i,
  output edac_pkg::edac_status_t                 status_o,
  input  wire logic [IN_DATA_W-1:0]              s_data_i,
  input  wire logic                              s_last_i,
  output logic [edac_pkg::OUT_DATA_W-1:0]        m_data_o,
  output logic                                   m_user_o
);
  import edac_pkg::*;

  localparam int DIFF_W = ELEM_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ACC_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W);

  // Element stage: difference, magnitude and square of the incoming pair.
  logic signed [DIFF_W-1:0] a_ext, b_ext, diff;
  logic [DIFF_W-1:0]        mag;
  logic [SQ_W-1:0]          sq;
  logic                     cnt_full;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]  sq_q;
  logic             v1_q, last1_q, over1_q;

  assign a_ext    = DIFF_W'($signed(s_data_i[ELEM_BITS-1:0]));
  assign b_ext    = DIFF_W'($signed(s_data_i[2*ELEM_BITS-1:ELEM_BITS]));
  assign diff     = a_ext - b_ext;
  assign mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign sq       = SQ_W'(mag) * SQ_W'(mag);
  assign cnt_full = (cnt_q == CNT_W'(MAX_DIM));

  always_comb begin
    cnt_d = cnt_q;
    if (s_last_i) begin
      cnt_d = '0;
    end else if (!cnt_full) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      v1_q <= cmd_i.accept;
      if (cmd_i.accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sq_q    <= sq;
      last1_q <= s_last_i;
      over1_q <= cnt_full;
    end
  end

  // Accumulate stage with saturation at the all-ones sum.
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             sat_q, sat_d;
  logic [ACC_W-1:0] total;

  assign total = ACC_W'(sum_q) + ACC_W'(sq_q);

  always_comb begin
    sum_d = SUM_W'(total);
    sat_d = sat_q;
    if (over1_q || (total > ACC_W'(SUM_MAX))) begin
      sum_d = SUM_MAX;
      sat_d = 1'b1;
    end
  end

  // Square root unit: one result bit per step, two radicand bits consumed.
  logic [SUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [STEP_W-1:0] step_q;
  logic              rsat_q;
  logic [REM_W+1:0]  rem_t, trial;
  logic              fits;

  assign rem_t = {rem_q, rad_q[SUM_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_q, 2'b01});
  assign fits  = (rem_t >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      sat_q  <= 1'b0;
      step_q <= '0;
    end else begin
      if (v1_q) begin
        if (last1_q) begin
          sum_q  <= '0;
          sat_q  <= 1'b0;
          step_q <= '0;
        end else begin
          sum_q <= sum_d;
          sat_q <= sat_d;
        end
      end else if (cmd_i.root_step) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && last1_q) begin
      rad_q  <= sum_d;
      rsat_q <= sat_d;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= fits ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign status_o.root_last = (step_q == STEP_W'(ROOT_W - 1));

  // Output register, distance clamped to DIST_W bits.
  logic [DIST_W-1:0] dist_q;
  logic              ovf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      dist_q <= (|root_q[ROOT_W-1:DIST_W]) ? {DIST_W{1'b1}} : root_q[DIST_W-1:0];
      ovf_q  <= rsat_q;
    end
  end

  assign m_data_o = OUT_DATA_W'(dist_q);
  assign m_user_o = ovf_q;

endmodule
`default_nettype wire

// ----- rtl/core/euclidean_distance_accumulator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euclidean_distance_accumulator_core
// Streaming L2 distance: sums squared element differences and emits the
// floor square root of the sum once the last beat of each vector is in.
// ----------------------------------------------------------------------------
// Element pairs are taken one beat per clock while a vector streams in. The
// beat marked tlast closes the vector: the input then stalls while a
// bit-serial square root produces one result bit per cycle, a 22-bit root
// for the 44-bit sum. The result sits in an output register, so the next
// vector streams in while it waits to be taken. A vector longer than
// MAX_DIM saturates the sum, reads as the clamped maximum distance and sets
// the overflow flag in tuser.
module euclidean_distance_accumulator_core #(
  parameter int MAX_DIM   = edac_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = edac_pkg::ELEM_BITS_DEF,
  parameter int IN_DATA_W = ((2 * ELEM_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // a_elem [ELEM_BITS-1:0], b_elem [2*ELEM_BITS-1:ELEM_BITS], zero padded
  input  wire logic [IN_DATA_W-1:0]           s_axis_tdata_i,
  input  wire logic                           s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // distance [20:0], zero padded
  output logic [edac_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // overflow [0]
  output logic                                m_axis_tuser_o
);
  import edac_pkg::*;

  edac_cmd_t    cmd;
  edac_status_t status;

  edac_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  edac_dp #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS),
    .IN_DATA_W (IN_DATA_W)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .s_data_i (s_axis_tdata_i),
    .s_last_i (s_axis_tlast_i),
    .m_data_o (m_axis_tdata_o),
    .m_user_o (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
